// ===== src/piecewise_linear_calibration_assert.svh =====
// Assertion macros for the piecewise-linear calibration block.
// Included by the RTL files that check their own logic; expects clk and rst in scope.
`ifndef PIECEWISE_LINEAR_CALIBRATION_ASSERT_SVH
`define PIECEWISE_LINEAR_CALIBRATION_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset
`define PLC_ASSERT(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("plc check failed");
// Condition in one cycle that implies another in the next cycle
`define PLC_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("plc check failed");
`else
`define PLC_ASSERT(name, cond)
`define PLC_ASSERT_NEXT(name, pre, post)
`endif
`endif

// ===== src/plc_pkg.sv =====
// Package for the piecewise-linear calibration block: breakpoint tables, widths,
// direction codes and the bus that runs down the cell chain. No dependencies.
`default_nettype none

package plc_pkg;

  localparam int STORED_POINTS = 28;
  localparam int CODE_W        = 8;
  localparam int KEY_W         = 16;
  localparam int COUNT_W       = 15;
  localparam int SLOPE_W       = 9;
  localparam int RESULT_W      = 15;

  // Conversion direction, carried in tuser
  localparam logic KIND_CODE_TO_COUNT = 1'b0;
  localparam logic KIND_COUNT_TO_CODE = 1'b1;

  localparam logic [RESULT_W-1:0] COUNT_FULL_SCALE = 15'h7FFF;
  localparam logic [CODE_W-1:0]   CODE_FULL_SCALE  = 8'd255;

  localparam logic [CODE_W-1:0] CODE_POINTS [STORED_POINTS] = '{
    8'd0,   8'd5,   8'd10,  8'd15,  8'd20,  8'd25,  8'd30,  8'd35,  8'd40,  8'd45,
    8'd50,  8'd55,  8'd60,  8'd65,  8'd70,  8'd75,  8'd80,  8'd85,  8'd90,  8'd95,
    8'd100, 8'd105, 8'd110, 8'd120, 8'd130, 8'd140, 8'd150, 8'd160
  };

  localparam logic [COUNT_W-1:0] COUNT_POINTS [STORED_POINTS] = '{
    15'd0,     15'd314,   15'd839,   15'd1965,  15'd3079,  15'd4365,  15'd5815,
    15'd7407,  15'd9108,  15'd10997, 15'd12747, 15'd14861, 15'd16575, 15'd18008,
    15'd19451, 15'd20622, 15'd21763, 15'd22803, 15'd23506, 15'd24264, 15'd25050,
    15'd25668, 15'd26277, 15'd27385, 15'd28062, 15'd28456, 15'd28839, 15'd29137
  };

  // Truncated slope of the segment that ends at each breakpoint (first entry unused)
  localparam logic [SLOPE_W-1:0] SEG_SLOPES [STORED_POINTS] = '{
    9'd0,   9'd62,  9'd105, 9'd225, 9'd222, 9'd257, 9'd290, 9'd318, 9'd340, 9'd377,
    9'd350, 9'd422, 9'd342, 9'd286, 9'd288, 9'd234, 9'd228, 9'd208, 9'd140, 9'd151,
    9'd157, 9'd123, 9'd121, 9'd110, 9'd67,  9'd39,  9'd38,  9'd29
  };

  // Request travelling down the breakpoint chain
  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [KEY_W-1:0]   key;
    logic               done;    // segment or exact match found
    logic               interp;  // interpolation needed
    logic [CODE_W-1:0]  lo_code;
    logic [COUNT_W-1:0] lo_count;
    logic [SLOPE_W-1:0] slope;
  } cell_bus_t;

endpackage

`default_nettype wire

// ===== src/plc_cell.sv =====
// One breakpoint cell of the calibration chain: compares the request with its
// breakpoint and passes it on, registered. Depends on plc_pkg.
`default_nettype none

module plc_cell #(
  parameter int INDEX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire plc_pkg::cell_bus_t bus_in,
  output plc_pkg::cell_bus_t     bus_out
);

  localparam int LO_IDX = (INDEX == 0) ? 0 : INDEX - 1;

  localparam logic [plc_pkg::CODE_W-1:0]  PT_CODE  = plc_pkg::CODE_POINTS[INDEX];
  localparam logic [plc_pkg::COUNT_W-1:0] PT_COUNT = plc_pkg::COUNT_POINTS[INDEX];
  localparam logic [plc_pkg::CODE_W-1:0]  LO_CODE  = plc_pkg::CODE_POINTS[LO_IDX];
  localparam logic [plc_pkg::COUNT_W-1:0] LO_COUNT = plc_pkg::COUNT_POINTS[LO_IDX];
  localparam logic [plc_pkg::SLOPE_W-1:0] SLOPE    = plc_pkg::SEG_SLOPES[INDEX];

  plc_pkg::cell_bus_t             bus_next;
  logic [plc_pkg::KEY_W-1:0]      point_key;

  // Compare with this breakpoint in the selected direction
  always_comb begin
    bus_next = bus_in;
    if (bus_in.kind == plc_pkg::KIND_COUNT_TO_CODE) begin
      point_key = {1'b0, PT_COUNT};
    end else begin
      point_key = {8'd0, PT_CODE};
    end
    if (bus_in.valid && !bus_in.done) begin
      if (point_key == bus_in.key) begin
        bus_next.done     = 1'b1;
        bus_next.interp   = 1'b0;
        bus_next.lo_code  = PT_CODE;
        bus_next.lo_count = PT_COUNT;
      end else if (point_key > bus_in.key) begin
        bus_next.done = 1'b1;
        if (INDEX == 0) begin
          // below the first breakpoint: return its paired value
          bus_next.interp   = 1'b0;
          bus_next.lo_code  = PT_CODE;
          bus_next.lo_count = PT_COUNT;
        end else begin
          bus_next.interp   = 1'b1;
          bus_next.lo_code  = LO_CODE;
          bus_next.lo_count = LO_COUNT;
          bus_next.slope    = SLOPE;
        end
      end
    end
  end

  // Hand the request to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_out.valid <= 1'b0;
    end else begin
      bus_out <= bus_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/plc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the count-to-current path.
// Depends on plc_pkg for operand widths.
`default_nettype none

module plc_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [plc_pkg::KEY_W-1:0]   dividend,
  input  wire logic [plc_pkg::SLOPE_W-1:0] divisor,
  output logic                             done,
  output logic [plc_pkg::KEY_W-1:0]        quotient
);

  localparam int STEPS = plc_pkg::KEY_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic                         busy;
  logic [CNT_W-1:0]             cnt;
  logic [plc_pkg::SLOPE_W-1:0]  rem;
  logic [plc_pkg::SLOPE_W-1:0]  dsr;
  logic [plc_pkg::SLOPE_W:0]    shifted;
  logic [plc_pkg::SLOPE_W:0]    trial;
  logic                         ge;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    shifted = {rem, quotient[plc_pkg::KEY_W-1]};
    trial   = shifted - {1'b0, dsr};
    ge      = (shifted >= {1'b0, dsr});
  end

  // Control: step count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[plc_pkg::KEY_W-2:0], ge};
      rem      <= ge ? trial[plc_pkg::SLOPE_W-1:0] : shifted[plc_pkg::SLOPE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/piecewise_linear_calibration.sv =====
// Piecewise-linear calibration between current code and accumulated ADC count.
// Block use:
//   Input stream s_axis: tuser selects the direction (0: current code to count,
//   1: count to current code), tdata carries current_code and adc_count.
//   Output stream m_axis: tdata carries result_value, tuser carries overrange.
//   One request is converted at a time. It runs down a chain of one cell per
//   breakpoint (TABLE_POINTS, clamped to 2..28), one cell per cycle, then the
//   controller picks the outcome in S_SCAN. Current-to-count interpolation adds
//   a multiply state; count-to-current interpolation runs a bit-serial divider.
//   The next request is taken the cycle after the result enters the output
//   register. Reset clears the chain, the controller and the output valid; no
//   table needs clearing. A stalled receiver holds the result in the output
//   register; one further request may then be converted and waits until the
//   register frees.
// Depends on plc_pkg, plc_cell, plc_div and the assertion macro header.
`default_nettype none
`include "piecewise_linear_calibration_assert.svh"

module piecewise_linear_calibration #(
  parameter int TABLE_POINTS = 28
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [7:0] current_code, [23:8] adc_count
  input  wire logic        s_axis_tuser,   // [0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [14:0] result_value, [15] zero
  output logic             m_axis_tuser    // [0] overrange
);

  localparam int USED_POINTS =
    (TABLE_POINTS > plc_pkg::STORED_POINTS) ? plc_pkg::STORED_POINTS :
    ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t                           state, state_next;
  plc_pkg::cell_bus_t               chain [USED_POINTS+1];
  plc_pkg::cell_bus_t               tail;
  plc_pkg::cell_bus_t               seg, seg_next;
  logic [plc_pkg::RESULT_W-1:0]     res, res_next;
  logic                             ovr, ovr_next;
  logic                             accept;
  logic                             out_load;
  logic                             div_start;
  logic                             div_done;
  logic [plc_pkg::KEY_W-1:0]        div_q;
  logic [plc_pkg::KEY_W-1:0]        div_dividend;
  logic [plc_pkg::CODE_W-1:0]       code_diff;
  logic [plc_pkg::CODE_W+plc_pkg::SLOPE_W-1:0] product;
  logic [plc_pkg::CODE_W-1:0]       code_sum;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign tail          = chain[USED_POINTS];

  // Build the request at the head of the chain
  always_comb begin
    chain[0]          = '0;
    chain[0].valid    = accept;
    chain[0].kind     = s_axis_tuser;
    if (s_axis_tuser == plc_pkg::KIND_COUNT_TO_CODE) begin
      chain[0].key = s_axis_tdata[23:8];
    end else begin
      chain[0].key = {8'd0, s_axis_tdata[7:0]};
    end
  end

  // One cell per breakpoint
  for (genvar g = 0; g < USED_POINTS; g++) begin : g_cell
    plc_cell #(
      .INDEX (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .bus_in  (chain[g]),
      .bus_out (chain[g+1])
    );
  end

  assign div_dividend = tail.key - {1'b0, tail.lo_count};

  plc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (tail.slope),
    .done     (div_done),
    .quotient (div_q)
  );

  // Interpolation arithmetic
  always_comb begin
    code_diff = seg.key[plc_pkg::CODE_W-1:0] - seg.lo_code;
    product   = code_diff * seg.slope;
    code_sum  = seg.lo_code + div_q[plc_pkg::CODE_W-1:0];
  end

  assign out_load = (state == S_HOLD) && (!m_axis_tvalid || m_axis_tready);

  // Controller: pick the outcome at the chain end, then interpolate
  always_comb begin
    state_next = state;
    seg_next   = seg;
    res_next   = res;
    ovr_next   = ovr;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail.valid) begin
          seg_next = tail;
          ovr_next = 1'b0;
          priority if (!tail.done) begin
            ovr_next   = 1'b1;
            res_next   = (tail.kind == plc_pkg::KIND_COUNT_TO_CODE) ?
                         {7'd0, plc_pkg::CODE_FULL_SCALE} : plc_pkg::COUNT_FULL_SCALE;
            state_next = S_HOLD;
          end else if (!tail.interp) begin
            res_next   = (tail.kind == plc_pkg::KIND_COUNT_TO_CODE) ?
                         {7'd0, tail.lo_code} : tail.lo_count;
            state_next = S_HOLD;
          end else if (tail.kind == plc_pkg::KIND_CODE_TO_COUNT) begin
            state_next = S_MUL;
          end else if (tail.slope == '0) begin
            res_next   = {7'd0, tail.lo_code};
            state_next = S_HOLD;
          end else begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_MUL: begin
        res_next   = plc_pkg::RESULT_W'({2'b00, seg.lo_count} + product);
        state_next = S_HOLD;
      end
      S_DIV: begin
        if (div_done) begin
          res_next   = {7'd0, code_sum};
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    seg <= seg_next;
    res <= res_next;
    ovr <= ovr_next;
  end

  // Output register: load a finished result, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {1'b0, res};
      m_axis_tuser <= ovr;
    end
  end

  `PLC_ASSERT(a_state_onehot, $onehot(state))
  `PLC_ASSERT(a_tail_in_scan, !tail.valid || state == S_SCAN)
  `PLC_ASSERT(a_div_done_in_div, !div_done || state == S_DIV)
  `PLC_ASSERT_NEXT(a_accept_enters_chain, accept, chain[1].valid)
  `PLC_ASSERT(a_overrange_full_scale, !(m_axis_tvalid && m_axis_tuser) ||
              m_axis_tdata[14:0] == plc_pkg::COUNT_FULL_SCALE || m_axis_tdata[14:0] == 15'd255)

endmodule

`default_nettype wire

// ===== tb/sv/piecewise_linear_calibration_tb.sv =====
// Testbench for piecewise_linear_calibration: drives conversions in both directions,
// predicts each result from its own breakpoint table and checks every output request.
// Depends on plc_pkg and the piecewise_linear_calibration RTL.
`timescale 1ns / 1ps

module piecewise_linear_calibration_tb;

  localparam int NUM_POINTS   = 28;
  localparam int RANDOM_ITEMS = 626;

  typedef struct packed {
    logic        kind;
    logic [7:0]  current_code;
    logic [15:0] adc_count;
  } conv_req_t;

  typedef struct packed {
    logic [14:0] result_value;
    logic        overrange;
  } conv_res_t;

  // Breakpoint pairs, ascending in both columns
  localparam int BP_CODE [NUM_POINTS] = '{
    0, 5, 10, 15, 20, 25, 30, 35, 40, 45, 50, 55, 60, 65,
    70, 75, 80, 85, 90, 95, 100, 105, 110, 120, 130, 140, 150, 160
  };
  localparam int BP_COUNT [NUM_POINTS] = '{
    0, 314, 839, 1965, 3079, 4365, 5815, 7407, 9108, 10997, 12747,
    14861, 16575, 18008, 19451, 20622, 21763, 22803, 23506, 24264,
    25050, 25668, 26277, 27385, 28062, 28456, 28839, 29137
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [7:0] current_code, [23:8] adc_count
  logic        s_axis_tuser  = 1'b0; // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [14:0] result_value, [15] zero
  logic        m_axis_tuser;         // [0] overrange

  conv_req_t pending_requests [$];
  conv_res_t expected_results [$];
  conv_req_t on_bus;
  int        sent_count    = 0;
  int        results_seen  = 0;
  int        error_count   = 0;

  piecewise_linear_calibration dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Truncated slope of the segment ending at breakpoint hi
  function automatic int segment_slope(int hi);
    int dc;
    int dx;
    dc = BP_COUNT[hi] - BP_COUNT[hi-1];
    dx = BP_CODE[hi] - BP_CODE[hi-1];
    return (dx == 0) ? 0 : dc / dx;
  endfunction

  // Expected conversion: exact breakpoint, interpolation from the lower point, or full scale
  function automatic conv_res_t predict_conversion(conv_req_t req);
    conv_res_t res;
    int        key;
    int        hi;
    int        slope;
    int        value;
    res = '0;
    key = (req.kind == plc_pkg::KIND_CODE_TO_COUNT) ? int'(req.current_code)
                                                     : int'(req.adc_count);
    hi  = NUM_POINTS;
    for (int i = NUM_POINTS - 1; i >= 0; i--) begin
      if (req.kind == plc_pkg::KIND_CODE_TO_COUNT ? (BP_CODE[i] >= key)
                                                  : (BP_COUNT[i] >= key))
        hi = i;
    end
    if (hi == NUM_POINTS) begin
      res.overrange    = 1'b1;
      res.result_value = (req.kind == plc_pkg::KIND_CODE_TO_COUNT) ?
                         plc_pkg::COUNT_FULL_SCALE : 15'(plc_pkg::CODE_FULL_SCALE);
    end else if (req.kind == plc_pkg::KIND_CODE_TO_COUNT) begin
      if (BP_CODE[hi] == key || hi == 0) begin
        value = BP_COUNT[hi];
      end else begin
        slope = segment_slope(hi);
        value = BP_COUNT[hi-1] + (key - BP_CODE[hi-1]) * slope;
      end
      res.result_value = 15'(value);
    end else begin
      if (BP_COUNT[hi] == key || hi == 0) begin
        value = BP_CODE[hi];
      end else begin
        slope = segment_slope(hi);
        value = BP_CODE[hi-1];
        if (slope != 0) value = value + (key - BP_COUNT[hi-1]) / slope;
      end
      res.result_value = 15'(value & 8'hFF);
    end
    return res;
  endfunction

  function automatic conv_req_t make_request(logic kind, int code, int count);
    conv_req_t req;
    req.kind         = kind;
    req.current_code = 8'(code);
    req.adc_count    = 16'(count);
    return req;
  endfunction

  // Driver: present queued requests, idling now and then outside the quiet window
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_conversion(on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() != 0 &&
            !(sent_count >= 250 && sent_count < 400) &&
            $urandom_range(0, 99) < 11) begin
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          on_bus         = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {on_bus.adc_count, on_bus.current_code};
          s_axis_tuser  <= on_bus.kind;
          sent_count    <= sent_count + 1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink: stall now and then, except in the quiet window
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (!(results_seen >= 250 && results_seen < 400) &&
                 $urandom_range(0, 99) < 11) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: compare each output request with the oldest expectation
  always @(posedge clk) begin
    conv_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("unexpected result: result_value %0d, overrange %0b",
               m_axis_tdata[14:0], m_axis_tuser);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[14:0] !== want.result_value) begin
          $error("result_value: expected %0d, actual %0d",
                 want.result_value, m_axis_tdata[14:0]);
          error_count++;
        end
        if (m_axis_tuser !== want.overrange) begin
          $error("overrange: expected %0b, actual %0b", want.overrange, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[15] !== 1'b0) begin
          $error("tdata pad: expected 0, actual %0b", m_axis_tdata[15]);
          error_count++;
        end
      end
    end
  end

  // Stimulus: directed corners, then random conversions in both directions
  initial begin
    int pick;
    int code;
    int count;
    // current code to count: ends, breakpoints, both sides of them, overrange
    pending_requests.push_back(make_request(plc_pkg::KIND_CODE_TO_COUNT, 0, 16'hFFFF));
    pending_requests.push_back(make_request(plc_pkg::KIND_CODE_TO_COUNT, 1, 0));
    pending_requests.push_back(make_request(plc_pkg::KIND_CODE_TO_COUNT, 4, $urandom));
    pending_requests.push_back(make_request(plc_pkg::KIND_CODE_TO_COUNT, 5, $urandom));
    pending_requests.push_back(make_request(plc_pkg::KIND_CODE_TO_COUNT, 6, $urandom));
    pending_requests.push_back(make_request(plc_pkg::KIND_CODE_TO_COUNT, 80, $urandom));
    pending_requests.push_back(make_request(plc_pkg::KIND_CODE_TO_COUNT, 110, $urandom));
    pending_requests.push_back(make_request(plc_pkg::KIND_CODE_TO_COUNT, 115, $urandom));
    pending_requests.push_back(make_request(plc_pkg::KIND_CODE_TO_COUNT, 159, $urandom));
    pending_requests.push_back(make_request(plc_pkg::KIND_CODE_TO_COUNT, 160, $urandom));
    pending_requests.push_back(make_request(plc_pkg::KIND_CODE_TO_COUNT, 161, $urandom));
    pending_requests.push_back(make_request(plc_pkg::KIND_CODE_TO_COUNT, 255, $urandom));
    // count to current code: same corners on the count axis
    pending_requests.push_back(make_request(plc_pkg::KIND_COUNT_TO_CODE, 255, 0));
    pending_requests.push_back(make_request(plc_pkg::KIND_COUNT_TO_CODE, 0, 1));
    pending_requests.push_back(make_request(plc_pkg::KIND_COUNT_TO_CODE, $urandom, 313));
    pending_requests.push_back(make_request(plc_pkg::KIND_COUNT_TO_CODE, $urandom, 314));
    pending_requests.push_back(make_request(plc_pkg::KIND_COUNT_TO_CODE, $urandom, 315));
    pending_requests.push_back(make_request(plc_pkg::KIND_COUNT_TO_CODE, $urandom, 20000));
    pending_requests.push_back(make_request(plc_pkg::KIND_COUNT_TO_CODE, $urandom, 27384));
    pending_requests.push_back(make_request(plc_pkg::KIND_COUNT_TO_CODE, $urandom, 29136));
    pending_requests.push_back(make_request(plc_pkg::KIND_COUNT_TO_CODE, $urandom, 29137));
    pending_requests.push_back(make_request(plc_pkg::KIND_COUNT_TO_CODE, $urandom, 29138));
    pending_requests.push_back(make_request(plc_pkg::KIND_COUNT_TO_CODE, $urandom, 32768));
    pending_requests.push_back(make_request(plc_pkg::KIND_COUNT_TO_CODE, $urandom, 65535));

    // Mostly inside the table, some exact breakpoints, some anywhere in range
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick  = $urandom_range(0, 99);
      code  = $urandom_range(0, 165);
      count = $urandom_range(0, 29300);
      if (pick < 10) begin
        code  = BP_CODE[$urandom_range(0, NUM_POINTS - 1)];
        count = BP_COUNT[$urandom_range(0, NUM_POINTS - 1)];
      end else if (pick < 25) begin
        code  = $urandom_range(0, 255);
        count = $urandom_range(0, 65535);
      end
      if ($urandom_range(0, 1) == 0)
        pending_requests.push_back(make_request(plc_pkg::KIND_CODE_TO_COUNT, code,
                                                $urandom_range(0, 65535)));
      else
        pending_requests.push_back(make_request(plc_pkg::KIND_COUNT_TO_CODE,
                                                $urandom_range(0, 255), count));
    end

    // Hold reset, then release it for good
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Drain: all requests sent and every result back, then idle before the verdict
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (120) @(posedge clk);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("FAIL");
    $finish;
  end

endmodule
